### src/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

    localparam int WORD_BITS_DEFAULT = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // Divider operand selection.
    typedef enum logic [1:0] {
        DIV_GCD = 2'd0,  // gcd modulo
        DIV_NUM = 2'd1,  // reduce numerator
        DIV_DEN = 2'd2   // reduce denominator
    } div_sel_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // capture operands
        logic prod1;     // form first products
        logic prod2;     // form second products and combine
        logic gcd_init;  // load gcd registers from n and d
        logic div_step;  // one restoring division step
        logic div_start; // start a division (load dividend/divisor)
        div_sel_t div_sel; // which division is started
        logic gcd_swap;  // a <= b, b <= remainder
        logic store_q;   // store quotient of reduce division
        logic finish;    // form output
    } cmd_t;

    // Status back to controller.
    typedef struct packed {
        logic early_err;  // zero denominator or divide by zero
        logic ovf;        // intermediate overflow
        logic b_zero;     // gcd divisor reached zero
        logic div_done;   // last division step done
    } stat_t;

endpackage

### src/rau_datapath.sv
// Datapath: operand registers, product multipliers, a shared bit-serial divider.
module rau_datapath
    import rau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEFAULT
)(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [1:0]  operation,
    input  logic [31:0] left_num,
    input  logic [31:0] left_den,
    input  logic [31:0] right_num,
    input  logic [31:0] right_den,
    output logic [31:0] result_num,
    output logic [30:0] result_den,
    output logic [1:0]  status
);
    localparam int W  = WORD_BITS;
    localparam int PW = 2 * WORD_BITS;
    localparam int CW = $clog2(WORD_BITS + 1);

    logic [1:0]          op_reg;
    logic signed [W-1:0] ln_reg, ld_reg, rn_reg, rd_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, n_reg, d_reg;
    logic signed [PW:0]   sum_w;
    logic                 ovf_reg, err_reg;
    logic [1:0]           st_reg;
    logic [W-1:0] a_reg, b_reg, q_reg, rem_reg, dv_reg, qn_reg;
    logic [CW-1:0] cnt_reg;
    logic         neg_n_reg, neg_d_reg;
    logic signed [PW-1:0] m1, m2;
    logic [W:0]   trial;
    logic [W-1:0] rem_next;
    logic [W-1:0] dividend;

    function automatic logic fits(input logic signed [PW:0] v);
        logic signed [PW:0] hi;
        logic signed [PW:0] lo;
        begin
            hi = (PW+1)'((64'd1 << (W - 1)) - 64'd1);
            lo = -hi - (PW+1)'(1);
            fits = (v >= lo) && (v <= hi);
        end
    endfunction

    always_comb
    begin
        m1 = ln_reg * rd_reg;
        m2 = ld_reg * rn_reg;
        unique case (op_t'(op_reg))
            OP_MUL:  m1 = ln_reg * rn_reg;
            default: ;
        endcase
        sum_w = (op_reg == OP_SUB) ? {p1_reg[PW-1], p1_reg} - {p2_reg[PW-1], p2_reg}
                                   : {p1_reg[PW-1], p1_reg} + {p2_reg[PW-1], p2_reg};
        trial = {rem_reg, q_reg[W-1]} - {1'b0, dv_reg};
        rem_next = trial[W] ? {rem_reg[W-2:0], q_reg[W-1]} : trial[W-1:0];
    end

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_NUM: dividend = n_reg[PW-1] ? W'(-n_reg) : n_reg[W-1:0];
            DIV_DEN: dividend = d_reg[PW-1] ? W'(-d_reg) : d_reg[W-1:0];
            default: dividend = a_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            err_reg <= 1'b0;
            st_reg  <= ST_OK;
        end
        else
        begin
            if (cmd.load)
            begin
                op_reg  <= operation;
                ln_reg  <= left_num[W-1:0];
                ld_reg  <= left_den[W-1:0];
                rn_reg  <= right_num[W-1:0];
                rd_reg  <= right_den[W-1:0];
                ovf_reg <= 1'b0;
                if (left_den[W-1:0] == '0 || right_den[W-1:0] == '0)
                begin
                    err_reg <= 1'b1;
                    st_reg  <= ST_ZERO_DEN;
                end
                else if (operation == OP_DIV && right_num[W-1:0] == '0)
                begin
                    err_reg <= 1'b1;
                    st_reg  <= ST_DIV_ZERO;
                end
                else
                begin
                    err_reg <= 1'b0;
                    st_reg  <= ST_OK;
                end
            end
            if (cmd.prod1)
            begin
                p1_reg <= m1;
                p2_reg <= m2;
                if (op_reg == OP_ADD || op_reg == OP_SUB)
                begin
                    if (!fits({m1[PW-1], m1}) || !fits({m2[PW-1], m2}))
                        ovf_reg <= 1'b1;
                end
            end
            if (cmd.prod2)
            begin
                // denominator product: ld*rd except for divide, ld*rn
                if (op_reg == OP_DIV)
                begin
                    n_reg <= p1_reg;
                    d_reg <= p2_reg;
                end
                else if (op_reg == OP_MUL)
                begin
                    n_reg <= p1_reg;
                    d_reg <= ld_reg * rd_reg;
                end
                else
                begin
                    n_reg <= sum_w[PW-1:0];
                    d_reg <= ld_reg * rd_reg;
                    if (!fits(sum_w))
                        ovf_reg <= 1'b1;
                end
            end
            if (cmd.gcd_init)
            begin
                if (!fits({n_reg[PW-1], n_reg}) || !fits({d_reg[PW-1], d_reg}))
                    ovf_reg <= 1'b1;
                a_reg     <= n_reg[PW-1] ? W'(-n_reg) : n_reg[W-1:0];
                b_reg     <= d_reg[PW-1] ? W'(-d_reg) : d_reg[W-1:0];
                neg_n_reg <= n_reg[PW-1];
                neg_d_reg <= d_reg[PW-1];
            end
            if (cmd.div_start)
            begin
                q_reg   <= dividend;
                rem_reg <= '0;
                dv_reg  <= (cmd.div_sel == DIV_GCD) ? b_reg : a_reg;
                cnt_reg <= CW'(W);
            end
            if (cmd.div_step)
            begin
                rem_reg <= rem_next;
                q_reg   <= {q_reg[W-2:0], ~trial[W]};
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (cmd.gcd_swap)
            begin
                // swap comes with the last step, so take the final remainder
                a_reg <= b_reg;
                b_reg <= rem_next;
            end
            if (cmd.store_q)
                qn_reg <= q_reg;
            if (cmd.finish)
            begin
                // qn = |n|/g, q = |d|/g; sign of result is neg_n xor neg_d
                if (err_reg || ovf_reg)
                begin
                    result_num <= '0;
                    result_den <= '0;
                    status     <= err_reg ? st_reg : ST_OVERFLOW;
                end
                else if (q_reg[W-1] || (qn_reg[W-1]
                         && !((neg_n_reg ^ neg_d_reg) && qn_reg[W-2:0] == '0)))
                begin
                    // only the most negative numerator may reach the top bit
                    result_num <= '0;
                    result_den <= '0;
                    status     <= ST_OVERFLOW;
                end
                else
                begin
                    result_num <= (neg_n_reg ^ neg_d_reg) ? 32'(-$signed({1'b0, qn_reg}))
                                                         : 32'(qn_reg);
                    result_den <= 31'(q_reg);
                    status     <= ST_OK;
                end
            end
        end
    end

    assign stat.early_err = err_reg;
    assign stat.ovf       = ovf_reg;
    assign stat.b_zero    = (b_reg == '0);
    assign stat.div_done  = (cnt_reg == CW'(1));

endmodule

### src/rau_ctrl.sv
// Controller state machine sequencing products, gcd and reduction divisions.
module rau_ctrl
    import rau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_tvalid,
    output logic  in_tready,
    output logic  out_tvalid,
    input  logic  out_tready,
    output cmd_t  cmd,
    input  stat_t stat
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_PROD1 = 11'b00000000010,
        S_PROD2 = 11'b00000000100,
        S_INIT  = 11'b00000001000,
        S_GTEST = 11'b00000010000,
        S_GDIV  = 11'b00000100000,
        S_NSTRT = 11'b00001000000,
        S_NDIV  = 11'b00010000000,
        S_DSTRT = 11'b00100000000,
        S_DDIV  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg;

    assign in_tready  = (state_reg == S_IDLE);
    assign out_tvalid = valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_tvalid;
                if (in_tvalid)
                    state_next = S_PROD1;
            end
            S_PROD1:
            begin
                cmd.prod1  = 1'b1;
                state_next = S_PROD2;
            end
            S_PROD2:
            begin
                cmd.prod2  = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.gcd_init = 1'b1;
                state_next   = S_GTEST;
            end
            S_GTEST:
            begin
                if (stat.early_err || stat.ovf)
                    state_next = S_OUT;
                else if (stat.b_zero)
                    state_next = S_NSTRT;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_GDIV;
                end
            end
            S_GDIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                    state_next = S_GTEST;
            end
            S_NSTRT:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_NUM;
                state_next    = S_NDIV;
            end
            S_NDIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                    state_next = S_DSTRT;
            end
            S_DSTRT:
            begin
                cmd.store_q   = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DEN;
                state_next    = S_DDIV;
            end
            S_DDIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!valid_reg || out_tready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // gcd swap comes with the last step of the modulo division
        if (state_reg == S_GDIV && stat.div_done)
            cmd.gcd_swap = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.finish)
                valid_reg <= 1'b1;
            else if (out_tready)
                valid_reg <= 1'b0;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_tvalid)
        else $error("finish without output valid");
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_tvalid && in_tready) |=> (state_reg == S_PROD1))
        else $error("accepted request not started");

endmodule

### src/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
// Each request carries two signed fractions and an operation; the block forms
// cross products with signed multipliers, reduces the result by a Euclidean gcd
// built on a shared restoring divider (one quotient bit per cycle), then
// divides numerator and denominator by that gcd with the same divider. One
// request is worked at a time, and the gcd takes at most about 46 Euclid
// steps for 32-bit words. A result waits in the output register while the
// next request is accepted. Errors give 0/0 and a status.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEFAULT
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // left_num, left_den, right_num, right_den
    input  logic [1:0]   s_tuser,  // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,  // result_num, result_den, zero pad
    output logic [1:0]   m_tuser   // status
);
    cmd_t        cmd;
    stat_t       stat;
    logic [31:0] result_num;
    logic [30:0] result_den;

    rau_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tvalid  (s_tvalid),
        .in_tready  (s_tready),
        .out_tvalid (m_tvalid),
        .out_tready (m_tready),
        .cmd        (cmd),
        .stat       (stat)
    );

    rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .operation  (s_tuser),
        .left_num   (s_tdata[31:0]),
        .left_den   (s_tdata[63:32]),
        .right_num  (s_tdata[95:64]),
        .right_den  (s_tdata[127:96]),
        .result_num (result_num),
        .result_den (result_den),
        .status     (m_tuser)
    );

    assign m_tdata = {1'b0, result_den, result_num};

endmodule

### sim/tb_rational_arithmetic_unit.sv
// Self-checking testbench for the rational arithmetic unit: random and corner fractions.
module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    // One predicted outcome of a request.
    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        status_t            status;
    } fraction_result_t;

    // Holds predicted results in request order and compares returned ones.
    class fraction_scoreboard;
        fraction_result_t pending[$];
        int mismatches;

        function bit fits(longint v);
            return v >= -64'sd2147483648 && v <= 64'sd2147483647;
        endfunction

        // Predict the reduced fraction for one request.
        function fraction_result_t predict(op_t op, logic signed [31:0] ln,
                                           logic signed [31:0] ld,
                                           logic signed [31:0] rn,
                                           logic signed [31:0] rd);
            fraction_result_t r;
            longint n;
            longint d;
            longint p1;
            longint p2;
            longint a;
            longint b;
            longint t;
            r.num = 0;
            r.den = 0;
            r.status = ST_OK;
            n = 0;
            d = 0;
            if (ld == 0 || rd == 0)
                r.status = ST_ZERO_DEN;
            else if (op == OP_DIV && rn == 0)
                r.status = ST_DIV_ZERO;
            else
            begin
                case (op) inside
                    OP_ADD, OP_SUB:
                    begin
                        p1 = longint'(ln) * longint'(rd);
                        p2 = longint'(ld) * longint'(rn);
                        if (!fits(p1) || !fits(p2))
                            r.status = ST_OVERFLOW;
                        else
                            n = (op == OP_ADD) ? p1 + p2 : p1 - p2;
                        d = longint'(ld) * longint'(rd);
                    end
                    OP_MUL:
                    begin
                        n = longint'(ln) * longint'(rn);
                        d = longint'(ld) * longint'(rd);
                    end
                    default:
                    begin
                        n = longint'(ln) * longint'(rd);
                        d = longint'(ld) * longint'(rn);
                    end
                endcase
                if (r.status == ST_OK && (!fits(n) || !fits(d)))
                    r.status = ST_OVERFLOW;
                if (r.status == ST_OK)
                begin
                    // Euclid on magnitudes, gcd taken positive
                    a = (n < 0) ? -n : n;
                    b = (d < 0) ? -d : d;
                    while (b != 0)
                    begin
                        t = a % b;
                        a = b;
                        b = t;
                    end
                    n = n / a;
                    d = d / a;
                    if (d < 0)
                    begin
                        n = -n;
                        d = -d;
                    end
                    if (!fits(n) || !fits(d))
                        r.status = ST_OVERFLOW;
                    else
                    begin
                        r.num = n[31:0];
                        r.den = d[30:0];
                    end
                end
            end
            return r;
        endfunction

        function void note_request(logic [1:0] op, logic [127:0] data);
            pending.push_back(predict(op_t'(op), data[31:0], data[63:32],
                                      data[95:64], data[127:96]));
        endfunction

        function void check_result(logic [63:0] data, logic [1:0] status);
            fraction_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result num=%0d den=%0d status=%0d",
                             $signed(data[31:0]), data[62:32], status);
                return;
            end
            want = pending.pop_front();
            if (data[31:0] !== want.num || data[62:32] !== want.den
                || data[63] !== 1'b0 || status !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
                             want.num, want.den, want.status,
                             $signed(data[31:0]), data[62:32], status);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // left_num, left_den, right_num, right_den
    logic [1:0]   s_tuser;   // operation
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // result_num, result_den, zero pad
    logic [1:0]   m_tuser;   // status

    fraction_scoreboard board;
    bit   idle_free;        // no idling on either side while set
    bit   hold_off;         // receiver stalls for a long stretch
    bit   stimulus_done;
    int   quiet_cycles = 0;

    rational_arithmetic_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Offer one request and hold it until accepted; insert random idle first.
    task automatic send_request(op_t op, logic [31:0] ln, logic [31:0] ld,
                                logic [31:0] rn, logic [31:0] rd);
        while (!idle_free && $urandom_range(99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {rd, rn, ld, ln};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Pick an operand value: mostly small, sometimes extreme or full range.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            3: return $urandom_range(65535) - 32768;
            4: return 32'd0;
            default: return $urandom_range(200) - 100;
        endcase
    endfunction

    // Receiver: random stalls, one long hold-off when asked.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= idle_free || ($urandom_range(99) >= 17);
    end

    // Check results and watch for progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] corner[6];
        op_t op;
        corner = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd0, 32'd1,
                   32'hAAAA_5555};
        board = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_ADD;
        idle_free = 1'b0;
        hold_off = 1'b0;
        stimulus_done = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed: every operation, zero denominators, divide by zero,
        // overflow of products, sums and reduced terms, zero result.
        for (int i = 0; i < 4; i++)
        begin
            op = op_t'(i);
            send_request(op, 32'd3, 32'd4, 32'd5, 32'hffff_fffa);
            send_request(op, 32'd1, 32'd0, 32'd1, 32'd2);
            send_request(op, 32'd0, 32'd7, 32'd0, 32'd3);
            send_request(op, corner[i], corner[i + 1], corner[i + 2],
                         32'hffff_ffff);
        end
        send_request(OP_DIV, 32'd5, 32'd0, 32'd0, 32'd1);
        send_request(OP_DIV, 32'd5, 32'd1, 32'd0, 32'd1);
        send_request(OP_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1);
        send_request(OP_MUL, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
        send_request(OP_DIV, 32'h8000_0000, 32'hffff_ffff, 32'd1, 32'd1);
        send_request(OP_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'd1);

        // Random: a stretch without idling, then a long receiver hold-off.
        for (int i = 0; i < 500; i++)
        begin
            idle_free = (i >= 100 && i < 180);
            if (i == 250)
            begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (3000) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            send_request(op_t'($urandom_range(3)), pick_value(),
                         ($urandom_range(19) == 0) ? 32'd0 : pick_value(),
                         pick_value(),
                         ($urandom_range(19) == 0) ? 32'd0 : pick_value());
        end
        s_tvalid <= 1'b0;
        idle_free = 1'b0;
        wait (!hold_off);
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
